// ----- rtl/apparent_wind_vector_top_defines.svh -----
// Assertion macros for the apparent wind block.
`ifndef APPARENT_WIND_VECTOR_TOP_DEFINES_SVH
`define APPARENT_WIND_VECTOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define AWV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define AWV_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define AWV_ASSERT(lbl, prop, msg)
`define AWV_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/awv_pkg.sv -----
package awv_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int STAGE_W       = $clog2(ATAN_ENTRIES);

    localparam int XW = 36;
    localparam int ZW = 33;

    localparam int DEG90     = 9000;
    localparam int DEG180    = 18000;
    localparam int DEG360    = 36000;
    localparam int SPEED_MAX = 20000;

    localparam logic [29:0]          KINV_Q30 = 30'd652032874;
    localparam logic signed [ZW-1:0] Z90      = ZW'(DEG90 * 65536);

    typedef struct packed {
        logic [15:0] course_ground;
        logic [13:0] speed_ground;
        logic [15:0] wind_direction;
        logic [13:0] wind_speed;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] true_angle;
        logic [14:0]        apparent_speed;
        logic [15:0]        apparent_angle;
    } t_out_word;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [15:0]   twa;
        logic [13:0]          sog;
        logic                 nz;
    } t_cord;

    typedef struct packed {
        logic  valid;
        t_cord data;
    } t_stage;

    // atan(2^-i) in hundredths of a degree times 2^16
    function automatic logic signed [ZW-1:0] atan_unit(input logic [STAGE_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(294912000);
            5'd1:    v = ZW'(174096719);
            5'd2:    v = ZW'(91987925);
            5'd3:    v = ZW'(46694507);
            5'd4:    v = ZW'(23437865);
            5'd5:    v = ZW'(11730358);
            5'd6:    v = ZW'(5866610);
            5'd7:    v = ZW'(2933484);
            5'd8:    v = ZW'(1466765);
            5'd9:    v = ZW'(733385);
            5'd10:   v = ZW'(366693);
            5'd11:   v = ZW'(183346);
            5'd12:   v = ZW'(91673);
            5'd13:   v = ZW'(45837);
            5'd14:   v = ZW'(22918);
            5'd15:   v = ZW'(11459);
            5'd16:   v = ZW'(5730);
            5'd17:   v = ZW'(2865);
            5'd18:   v = ZW'(1432);
            5'd19:   v = ZW'(716);
            5'd20:   v = ZW'(358);
            5'd21:   v = ZW'(179);
            5'd22:   v = ZW'(90);
            5'd23:   v = ZW'(45);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/awv_cordic_cell.sv -----
module awv_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vect,
    input  logic [awv_pkg::STAGE_W-1:0]  i_stage,
    input  awv_pkg::t_stage              i_up,
    output logic                         o_up_ready,
    output awv_pkg::t_stage              o_dn,
    input  logic                         i_dn_ready
);

    logic                         r_valid;
    awv_pkg::t_cord               r_data;
    awv_pkg::t_cord               n_data;
    logic signed [awv_pkg::XW-1:0] dx;
    logic signed [awv_pkg::XW-1:0] dy;
    logic signed [awv_pkg::ZW-1:0] da;
    logic                         dir;

    always_comb begin
        dx  = i_up.data.y >>> i_stage;
        dy  = i_up.data.x >>> i_stage;
        da  = awv_pkg::atan_unit(i_stage);
        dir = i_vect ? !i_up.data.y[awv_pkg::XW-1] : !i_up.data.z[awv_pkg::ZW-1];
        n_data = i_up.data;
        if (i_vect ^ dir) begin
            n_data.x = i_up.data.x - dx;
            n_data.y = i_up.data.y + dy;
            n_data.z = i_up.data.z - da;
        end else begin
            n_data.x = i_up.data.x + dx;
            n_data.y = i_up.data.y - dy;
            n_data.z = i_up.data.z + da;
        end
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up.valid) begin
            r_data <= n_data;
        end
    end

    assign o_dn.valid = r_valid;
    assign o_dn.data  = r_data;

endmodule

// ----- rtl/awv_prep.sv -----
module awv_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  awv_pkg::t_in_word i_in_word,
    output logic              o_in_ready,
    output awv_pkg::t_stage   o_dn,
    input  logic              i_dn_ready
);

    logic               r_a_valid;
    logic signed [16:0] r_a_diff;
    logic [29:0]        r_a_mag;
    logic [13:0]        r_a_sog;
    logic               r_b_valid;
    awv_pkg::t_cord     r_b_data;

    logic [15:0]        cog_red;
    logic [15:0]        twd_red;
    logic signed [16:0] n_a_diff;
    logic [43:0]        prod;
    logic signed [16:0] twa_w;
    logic signed [16:0] zq;
    logic signed [awv_pkg::XW-1:0] mag;
    awv_pkg::t_cord     n_b_data;
    logic               a_ready;
    logic               b_ready;

    always_comb begin
        cog_red = (i_in_word.course_ground >= 16'(awv_pkg::DEG360)) ?
                  i_in_word.course_ground - 16'(awv_pkg::DEG360) : i_in_word.course_ground;
        twd_red = (i_in_word.wind_direction >= 16'(awv_pkg::DEG360)) ?
                  i_in_word.wind_direction - 16'(awv_pkg::DEG360) : i_in_word.wind_direction;
        n_a_diff = $signed({1'b0, twd_red}) - $signed({1'b0, cog_red});
        prod = 44'(i_in_word.wind_speed) * 44'(awv_pkg::KINV_Q30) + 44'(8192);
    end

    always_comb begin
        if (r_a_diff <= -17'(awv_pkg::DEG180)) begin
            twa_w = r_a_diff + 17'(awv_pkg::DEG360);
        end else if (r_a_diff > 17'(awv_pkg::DEG180)) begin
            twa_w = r_a_diff - 17'(awv_pkg::DEG360);
        end else begin
            twa_w = r_a_diff;
        end
        mag = $signed({{(awv_pkg::XW-30){1'b0}}, r_a_mag});
        n_b_data     = '0;
        n_b_data.twa = twa_w[15:0];
        n_b_data.sog = r_a_sog;
        if (twa_w > 17'(awv_pkg::DEG90)) begin
            zq         = twa_w - 17'(awv_pkg::DEG90);
            n_b_data.y = mag;
        end else if (twa_w < -17'(awv_pkg::DEG90)) begin
            zq         = twa_w + 17'(awv_pkg::DEG90);
            n_b_data.y = -mag;
        end else begin
            zq         = twa_w;
            n_b_data.x = mag;
        end
        n_b_data.z = awv_pkg::ZW'(zq) <<< 16;
    end

    assign b_ready    = !r_b_valid || i_dn_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_in_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_in_valid) begin
            r_a_diff <= n_a_diff;
            r_a_mag  <= prod[43:14];
            r_a_sog  <= i_in_word.speed_ground;
        end
        if (b_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_dn.valid = r_b_valid;
    assign o_dn.data  = r_b_data;

endmodule

// ----- rtl/awv_bridge.sv -----
module awv_bridge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  awv_pkg::t_stage i_up,
    output logic            o_up_ready,
    output awv_pkg::t_stage o_dn,
    input  logic            i_dn_ready
);

    logic           r_p_valid;
    awv_pkg::t_cord r_p_data;
    logic           r_v_valid;
    awv_pkg::t_cord r_v_data;

    awv_pkg::t_cord n_p_data;
    awv_pkg::t_cord n_v_data;
    logic           p_ready;
    logic           v_ready;

    always_comb begin
        n_p_data   = i_up.data;
        n_p_data.x = i_up.data.x + $signed({{(awv_pkg::XW-30){1'b0}}, i_up.data.sog, 16'b0});
    end

    // start vectoring in the right half plane
    always_comb begin
        n_v_data    = r_p_data;
        n_v_data.nz = (r_p_data.x != '0) || (r_p_data.y != '0);
        if (r_p_data.x[awv_pkg::XW-1]) begin
            if (!r_p_data.y[awv_pkg::XW-1]) begin
                n_v_data.x = r_p_data.y;
                n_v_data.y = -r_p_data.x;
                n_v_data.z = awv_pkg::Z90;
            end else begin
                n_v_data.x = -r_p_data.y;
                n_v_data.y = r_p_data.x;
                n_v_data.z = -awv_pkg::Z90;
            end
        end else begin
            n_v_data.z = '0;
        end
    end

    assign v_ready    = !r_v_valid || i_dn_ready;
    assign p_ready    = !r_p_valid || v_ready;
    assign o_up_ready = p_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_v_valid <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_up.valid;
            end
            if (v_ready) begin
                r_v_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && i_up.valid) begin
            r_p_data <= n_p_data;
        end
        if (v_ready && r_p_valid) begin
            r_v_data <= n_v_data;
        end
    end

    assign o_dn.valid = r_v_valid;
    assign o_dn.data  = r_v_data;

endmodule

// ----- rtl/awv_post.sv -----
module awv_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  awv_pkg::t_stage    i_up,
    output logic               o_up_ready,
    output logic               o_out_valid,
    output awv_pkg::t_out_word o_out_word,
    input  logic               i_out_ready
);

    logic               r_q_valid;
    logic [15:0]        r_q_spd;
    logic signed [16:0] r_q_ang;
    logic signed [15:0] r_q_twa;
    logic               r_q_nz;
    logic               r_o_valid;
    awv_pkg::t_out_word r_o_word;

    logic [31:0]                   xc;
    logic [61:0]                   prod;
    logic signed [awv_pkg::ZW-1:0] zr;
    logic signed [16:0]            ang_w;
    awv_pkg::t_out_word            n_o_word;
    logic                          q_ready;
    logic                          o_ready;

    always_comb begin
        if (i_up.data.x[awv_pkg::XW-1]) begin
            xc = '0;
        end else if (|i_up.data.x[awv_pkg::XW-2:32]) begin
            xc = '1;
        end else begin
            xc = i_up.data.x[31:0];
        end
        prod = 62'(xc) * 62'(awv_pkg::KINV_Q30) + (62'(1) << 45);
        zr   = i_up.data.z + awv_pkg::ZW'(32768);
    end

    always_comb begin
        if (r_q_ang[16]) begin
            ang_w = r_q_ang + 17'(awv_pkg::DEG360);
        end else if (r_q_ang >= 17'(awv_pkg::DEG360)) begin
            ang_w = r_q_ang - 17'(awv_pkg::DEG360);
        end else begin
            ang_w = r_q_ang;
        end
        n_o_word.true_angle = r_q_twa;
        if (!r_q_nz) begin
            n_o_word.apparent_speed = '0;
            n_o_word.apparent_angle = '0;
        end else begin
            n_o_word.apparent_speed = (r_q_spd > 16'(awv_pkg::SPEED_MAX)) ?
                                      15'(awv_pkg::SPEED_MAX) : r_q_spd[14:0];
            n_o_word.apparent_angle = ang_w[15:0];
        end
    end

    assign o_ready    = !r_o_valid || i_out_ready;
    assign q_ready    = !r_q_valid || o_ready;
    assign o_up_ready = q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (q_ready) begin
                r_q_valid <= i_up.valid;
            end
            if (o_ready) begin
                r_o_valid <= r_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_ready && i_up.valid) begin
            r_q_spd <= prod[61:46];
            r_q_ang <= zr[awv_pkg::ZW-1:16];
            r_q_twa <= i_up.data.twa;
            r_q_nz  <= i_up.data.nz;
        end
        if (o_ready && r_q_valid) begin
            r_o_word <= n_o_word;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

endmodule

// ----- rtl/apparent_wind_vector_top.sv -----
// channel | direction | handshake                 | word
// input   | in        | i_in_valid / o_in_ready   | course, sog, wind dir, wind speed
// output  | out       | o_out_valid / i_out_ready | true angle, apparent speed, angle
//
// One word per cycle sustained while the output is ready; data passes through the rotation
// and vectoring cell chains plus six prep/bridge/post registers.
// Synchronous active-low reset empties every stage.
// Each stage loads when it is empty or its successor moves, so bubbles collapse;
// input ready drops only with every stage full and the output stalled.
`include "apparent_wind_vector_top_defines.svh"

module apparent_wind_vector_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  awv_pkg::t_in_word  i_in_word,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output awv_pkg::t_out_word o_out_word,
    input  logic               i_out_ready
);

    awv_pkg::t_stage s_rot [awv_pkg::CORDIC_STAGES+1];
    logic            rdy_rot [awv_pkg::CORDIC_STAGES+1];
    awv_pkg::t_stage s_vec [awv_pkg::CORDIC_STAGES+1];
    logic            rdy_vec [awv_pkg::CORDIC_STAGES+1];

    logic            spd_ok;
    logic            ang_ok;
    logic            twa_ok;

    awv_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_ready (o_in_ready),
        .o_dn       (s_rot[0]),
        .i_dn_ready (rdy_rot[0])
    );

    for (genvar k = 0; k < awv_pkg::CORDIC_STAGES; k++) begin : g_rot
        awv_cordic_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_vect     (1'b0),
            .i_stage    (awv_pkg::STAGE_W'(k)),
            .i_up       (s_rot[k]),
            .o_up_ready (rdy_rot[k]),
            .o_dn       (s_rot[k+1]),
            .i_dn_ready (rdy_rot[k+1])
        );
    end

    awv_bridge u_bridge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up       (s_rot[awv_pkg::CORDIC_STAGES]),
        .o_up_ready (rdy_rot[awv_pkg::CORDIC_STAGES]),
        .o_dn       (s_vec[0]),
        .i_dn_ready (rdy_vec[0])
    );

    for (genvar k = 0; k < awv_pkg::CORDIC_STAGES; k++) begin : g_vec
        awv_cordic_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_vect     (1'b1),
            .i_stage    (awv_pkg::STAGE_W'(k)),
            .i_up       (s_vec[k]),
            .o_up_ready (rdy_vec[k]),
            .o_dn       (s_vec[k+1]),
            .i_dn_ready (rdy_vec[k+1])
        );
    end

    awv_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_up        (s_vec[awv_pkg::CORDIC_STAGES]),
        .o_up_ready  (rdy_vec[awv_pkg::CORDIC_STAGES]),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

    assign spd_ok = o_out_word.apparent_speed <= 15'(awv_pkg::SPEED_MAX);
    assign ang_ok = o_out_word.apparent_angle < 16'(awv_pkg::DEG360);
    assign twa_ok = (o_out_word.true_angle > -16'(awv_pkg::DEG180)) &&
                    (o_out_word.true_angle <= 16'(awv_pkg::DEG180));

    `AWV_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `AWV_ASSERT(a_full_stall, !o_in_ready |-> (o_out_valid && !i_out_ready), "early input stall")
    `AWV_ASSERT(a_out_range, o_out_valid |-> (spd_ok && ang_ok), "apparent wind out of range")
    `AWV_ASSERT(a_twa_range, o_out_valid |-> twa_ok, "true angle out of range")

endmodule

// ----- dv/tb_apparent_wind_vector_top.sv -----
`timescale 1ns / 1ps

module tb_apparent_wind_vector_top;

    localparam longint GAIN_INV = 64'sd652032874;
    localparam int     N_RAND   = 1000;
    localparam int     N_DIR    = 21;
    localparam int     DRAIN    = 2 * awv_pkg::CORDIC_STAGES + 30;

    typedef struct packed {
        awv_pkg::t_in_word  word;
        logic               typed;
        awv_pkg::t_out_word want;
    } t_row;

    // atan(2^-i), hundredths of a degree << 16
    localparam longint ATAN_TAB [24] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466765, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    // input word: cog, sog, twd, tws; typed rows carry twa, aws, awa
    t_row dir_rows [N_DIR] = '{
        '{'{16'd0,     14'd0,     16'd0,     14'd0},     1'b1, '{16'sd0,     15'd0, 16'd0}},
        '{'{16'd0,     14'd0,     16'd18000, 14'd0},     1'b1, '{16'sd18000, 15'd0, 16'd0}},
        '{'{16'd18000, 14'd0,     16'd0,     14'd0},     1'b1, '{16'sd18000, 15'd0, 16'd0}},
        '{'{16'd0,     14'd0,     16'd35999, 14'd0},     1'b1, '{-16'sd1,    15'd0, 16'd0}},
        '{'{16'd35999, 14'd0,     16'd0,     14'd0},     1'b1, '{16'sd1,     15'd0, 16'd0}},
        '{'{16'd65535, 14'd0,     16'd65535, 14'd0},     1'b1, '{16'sd0,     15'd0, 16'd0}},
        '{'{16'd36000, 14'd0,     16'd9000,  14'd0},     1'b1, '{16'sd9000,  15'd0, 16'd0}},
        '{'{16'd9000,  14'd0,     16'd0,     14'd0},     1'b1, '{-16'sd9000, 15'd0, 16'd0}},
        '{'{16'd0,     14'd0,     16'd9001,  14'd1000},  1'b0, '0},
        '{'{16'd0,     14'd0,     16'd26999, 14'd1000},  1'b0, '0},
        '{'{16'd0,     14'd0,     16'd18000, 14'd1000},  1'b0, '0},
        '{'{16'd0,     14'd500,   16'd18000, 14'd1000},  1'b0, '0},
        '{'{16'd0,     14'd500,   16'd18000, 14'd500},   1'b0, '0},
        '{'{16'd0,     14'd10000, 16'd0,     14'd0},     1'b0, '0},
        '{'{16'd0,     14'd10000, 16'd0,     14'd10000}, 1'b0, '0},
        '{'{16'd0,     14'd16383, 16'd0,     14'd16383}, 1'b0, '0},
        '{'{16'd0,     14'd16383, 16'd18000, 14'd16383}, 1'b0, '0},
        '{'{16'd0,     14'd0,     16'd4500,  14'd10000}, 1'b0, '0},
        '{'{16'd12345, 14'd0,     16'd54321, 14'd16383}, 1'b0, '0},
        '{'{16'hAAAA,  14'h1FFF,  16'h5555,  14'h2AAA},  1'b0, '0},
        '{'{16'h5555,  14'h1555,  16'hAAAA,  14'h3FFF},  1'b0, '0}
    };

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    awv_pkg::t_in_word  in_word   = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    awv_pkg::t_out_word out_word;

    awv_pkg::t_out_word pending_wind [$];
    int                 mismatches = 0;
    int                 calm_left  = 0;

    apparent_wind_vector_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_word  (in_word),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .o_out_word (out_word),
        .i_out_ready(out_ready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic awv_pkg::t_out_word predict_wind(awv_pkg::t_in_word w);
        int                 cog, twd, twa, i;
        longint             sog, tws, mag, x, y, z, dx, dy, bx, by, t;
        longint unsigned    spd;
        awv_pkg::t_out_word r;
        cog = int'(w.course_ground);
        twd = int'(w.wind_direction);
        sog = longint'(w.speed_ground);
        tws = longint'(w.wind_speed);
        if (cog >= awv_pkg::DEG360) cog -= awv_pkg::DEG360;
        if (twd >= awv_pkg::DEG360) twd -= awv_pkg::DEG360;
        twa = twd - cog;
        if (twa <= -awv_pkg::DEG180) twa += awv_pkg::DEG360;
        else if (twa > awv_pkg::DEG180) twa -= awv_pkg::DEG360;

        mag = (tws * GAIN_INV + 64'sd8192) >>> 14;
        if (twa > awv_pkg::DEG90) begin
            x = 0; y = mag; z = longint'(twa - awv_pkg::DEG90) * 65536;
        end else if (twa < -awv_pkg::DEG90) begin
            x = 0; y = -mag; z = longint'(twa + awv_pkg::DEG90) * 65536;
        end else begin
            x = mag; y = 0; z = longint'(twa) * 65536;
        end
        for (i = 0; i < awv_pkg::CORDIC_STAGES && i < awv_pkg::ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end

        bx  = x + (sog <<< 16);
        by  = y;
        spd = 0;
        t   = 0;
        if (bx != 0 || by != 0) begin
            if (bx < 0) begin
                if (by >= 0) begin
                    x = by; y = -bx; z = longint'(awv_pkg::DEG90) * 65536;
                end else begin
                    x = -by; y = bx; z = -longint'(awv_pkg::DEG90) * 65536;
                end
            end else begin
                x = bx; y = by; z = 0;
            end
            for (i = 0; i < awv_pkg::CORDIC_STAGES && i < awv_pkg::ATAN_ENTRIES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += ATAN_TAB[i];
                end else begin
                    x -= dx; y += dy; z -= ATAN_TAB[i];
                end
            end
            if (x < 0) x = 0;
            spd = (unsigned'(x) * unsigned'(GAIN_INV) + (64'd1 << 45)) >> 46;
            if (spd > awv_pkg::SPEED_MAX) spd = awv_pkg::SPEED_MAX;
            t = (z + 32768) >>> 16;
            if (t < 0) t += awv_pkg::DEG360;
            if (t >= awv_pkg::DEG360) t -= awv_pkg::DEG360;
        end
        r.true_angle     = 16'(twa);
        r.apparent_speed = 15'(spd);
        r.apparent_angle = 16'(t);
        return r;
    endfunction

    function automatic awv_pkg::t_in_word rand_word();
        awv_pkg::t_in_word w;
        int                sel, off;
        int                offs [10] = '{0, 9000, -9000, 18000, 9001, -9001, 8999, -8999,
                                         17999, -17999};
        sel = $urandom_range(0, 99);
        w.course_ground  = 16'($urandom_range(0, awv_pkg::DEG360 - 1));
        w.wind_direction = 16'($urandom_range(0, awv_pkg::DEG360 - 1));
        w.speed_ground   = 14'($urandom_range(0, 10000));
        w.wind_speed     = 14'($urandom_range(0, 10000));
        if (sel < 12) begin
            w.course_ground  = 16'($urandom);
            w.wind_direction = 16'($urandom);
            w.speed_ground   = 14'($urandom);
            w.wind_speed     = 14'($urandom);
        end else if (sel < 30) begin
            off = offs[$urandom_range(0, 9)];
            w.wind_direction = 16'((int'(w.course_ground) + off + awv_pkg::DEG360)
                                   % awv_pkg::DEG360);
            if (sel < 20) w.wind_speed = w.speed_ground;
        end else if (sel < 36) begin
            if (sel[0]) w.speed_ground = '0;
            else w.wind_speed = '0;
        end
        return w;
    endfunction

    task automatic send_word(input awv_pkg::t_in_word w, input logic typed,
                             input awv_pkg::t_out_word want);
        int gap;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 150);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        pending_wind.push_back(typed ? want : predict_wind(w));
    endtask

    initial begin : drive_in
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        foreach (dir_rows[k]) send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
        repeat (N_RAND) send_word(rand_word(), 1'b0, '0);
        in_valid <= 1'b0;
        while (pending_wind.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : drive_out
        int run, stall;
        repeat (2) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) run = $urandom_range(200, 400);
            else run = $urandom_range(1, 40);
            out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        awv_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_wind.size() == 0) begin
                $error("unexpected word: %p", out_word);
                mismatches++;
            end else begin
                want = pending_wind.pop_front();
                if (out_word.true_angle !== want.true_angle) begin
                    $error("true_angle: expected %0d, got %0d",
                           want.true_angle, out_word.true_angle);
                    mismatches++;
                end
                if (out_word.apparent_speed !== want.apparent_speed) begin
                    $error("apparent_speed: expected %0d, got %0d",
                           want.apparent_speed, out_word.apparent_speed);
                    mismatches++;
                end
                if (out_word.apparent_angle !== want.apparent_angle) begin
                    $error("apparent_angle: expected %0d, got %0d",
                           want.apparent_angle, out_word.apparent_angle);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
